// File: rtl/core/dpm_pkg.sv
// shared types and fixed-point constants for the magnus dew point pipeline
package dpm_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SAT     = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [15:0] temperature_c;
        logic        [14:0] humidity_pct;
    } t_dpm_in;

    typedef struct packed {
        logic signed [15:0] dewpoint_c;
        t_status            status;
    } t_dpm_out;

    // magnus coefficients
    localparam logic [20:0] K_A_Q16     = 21'd1155072;
    localparam logic [23:0] K_B_Q16     = 24'd15927869;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [33:0] LN25600_Q30 = 34'd10898852780;

    // reciprocals ceil(2^33 / n) give exact floor division for 29-bit operands
    localparam int          RECIP_SH = 33;
    localparam logic [31:0] RECIP_3  = 32'd2863311531;
    localparam logic [31:0] RECIP_5  = 32'd1717986919;
    localparam logic [31:0] RECIP_7  = 32'd1227133514;
    localparam logic [31:0] RECIP_9  = 32'd954437177;

    // divider geometries
    localparam int A_NUM_W = 44;
    localparam int A_DEN_W = 25;
    localparam int A_QUO_W = 21;
    localparam int Z_NUM_W = 46;
    localparam int Z_DEN_W = 18;
    localparam int Z_QUO_W = 29;
    localparam int D_NUM_W = 45;
    localparam int D_DEN_W = 30;
    localparam int D_QUO_W = 17;

    // aligns the temperature term with the log series argument
    localparam int A_DLY = Z_QUO_W - A_QUO_W - 1;

endpackage

// File: rtl/core/dpm_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
module dpm_div_pipe #(
    parameter int NUM_W  = dpm_pkg::A_NUM_W,
    parameter int DEN_W  = dpm_pkg::A_DEN_W,
    parameter int QUO_W  = dpm_pkg::A_QUO_W,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    localparam int CMP_W = NUM_W + DEN_W;

    logic              r_valid [QUO_W];
    logic [QUO_W-1:0]  r_quo   [QUO_W];
    logic [SIDE_W-1:0] r_side  [QUO_W];
    logic [NUM_W-1:0]  r_rem   [QUO_W-1];
    logic [DEN_W-1:0]  r_den   [QUO_W-1];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int BIT = QUO_W - 1 - j;

        logic              valid_in;
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [SIDE_W-1:0] side_in;
        logic [CMP_W-1:0]  trial;
        logic              ge;
        logic [QUO_W-1:0]  n_quo;

        if (j == 0) begin : g_first
            assign valid_in = i_valid;
            assign rem_in   = i_num;
            assign den_in   = i_den;
            assign quo_in   = '0;
            assign side_in  = i_side;
        end else begin : g_next
            assign valid_in = r_valid[j-1];
            assign rem_in   = r_rem[j-1];
            assign den_in   = r_den[j-1];
            assign quo_in   = r_quo[j-1];
            assign side_in  = r_side[j-1];
        end

        assign trial = CMP_W'(den_in) << BIT;
        assign ge    = CMP_W'(rem_in) >= trial;

        always_comb begin
            n_quo      = quo_in;
            n_quo[BIT] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j]  <= n_quo;
                r_side[j] <= side_in;
            end
        end

        if (j < QUO_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= ge ? NUM_W'(CMP_W'(rem_in) - trial) : rem_in;
                    r_den[j] <= den_in;
                end
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

// File: rtl/core/dewpoint_magnus.sv
// magnus dew point, fully pipelined, one sample per cycle unless stalled
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------
//  input   | in        | i_valid / o_stall | i_data  (temperature, humidity)
//  output  | out       | o_valid / i_stall | o_data  (dew point, status)
//
//  a new transaction can enter every cycle unless o_stall is high; from
//  acceptance to o_valid it passes the three bit-serial divider pipelines
//  (29 + 17 stages on the critical path) plus the series and rounding stages
//  reset is synchronous, active low, and clears only the valid bits
//  a stalled output freezes the whole pipeline in place; nothing is dropped
module dewpoint_magnus (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  dpm_pkg::t_dpm_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output dpm_pkg::t_dpm_out o_data
);

    localparam int P_W = 29;

    // global advance: everything moves unless a held result is being stalled
    logic r_out_valid;
    dpm_pkg::t_dpm_out r_out_data;
    logic en;
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // ---------------------------------------------------------------- stage 1
    // temperature product and divisor, humidity normalized to [1,2)
    logic signed [23:0] w_tq16;
    logic signed [44:0] w_prod1;
    logic signed [25:0] w_d1;
    logic        [3:0]  w_k;
    logic        [31:0] w_mw;
    logic               w_zero;

    assign w_tq16  = {i_data.temperature_c, 8'd0};
    assign w_prod1 = 45'(w_tq16) * 45'(signed'({1'b0, dpm_pkg::K_A_Q16}));
    assign w_d1    = 26'(signed'({1'b0, dpm_pkg::K_B_Q16})) + 26'(w_tq16);
    assign w_zero  = i_data.humidity_pct == '0;

    // leading one position of the humidity sample
    always_comb begin
        w_k = '0;
        for (int b = 0; b < 15; b++) begin
            if (i_data.humidity_pct[b]) begin
                w_k = 4'(b);
            end
        end
    end
    assign w_mw = 32'(i_data.humidity_pct) << (5'd16 - {1'b0, w_k});

    logic               r1_valid;
    logic signed [44:0] r1_prod;
    logic        [24:0] r1_d1;
    logic        [15:0] r1_mfrac;
    logic        [3:0]  r1_k;
    logic               r1_zero;

    // ---------------------------------------------------------------- stage 2
    // rounding bias folded into the magnitude before the divide
    logic [43:0] w_mag1;
    assign w_mag1 = r1_prod[44] ? 44'(-r1_prod) : 44'(r1_prod);

    logic                        r2_valid;
    logic [dpm_pkg::A_NUM_W-1:0] r2_num;
    logic [dpm_pkg::A_DEN_W-1:0] r2_den;
    logic                        r2_sign;

    // ------------------------------------------------------------- dividers
    // z = (m-1)/(m+1) in q30, launched from stage 1
    logic                        w_zv;
    logic [dpm_pkg::Z_QUO_W-1:0] w_zq;
    logic [4:0]                  w_zside;

    dpm_div_pipe #(
        .NUM_W  (dpm_pkg::Z_NUM_W),
        .DEN_W  (dpm_pkg::Z_DEN_W),
        .QUO_W  (dpm_pkg::Z_QUO_W),
        .SIDE_W (5)
    ) u_zdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_valid),
        .i_num   ({r1_mfrac, 30'd0}),
        .i_den   ({2'b10, r1_mfrac}),
        .i_side  ({r1_k, r1_zero}),
        .o_valid (w_zv),
        .o_quo   (w_zq),
        .o_side  (w_zside)
    );

    // temperature term a = 17.625*t/(243.04+t), launched from stage 2
    logic                        w_av;
    logic [dpm_pkg::A_QUO_W-1:0] w_aq;
    logic                        w_as;

    dpm_div_pipe #(
        .NUM_W  (dpm_pkg::A_NUM_W),
        .DEN_W  (dpm_pkg::A_DEN_W),
        .QUO_W  (dpm_pkg::A_QUO_W),
        .SIDE_W (1)
    ) u_adiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_valid),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_side  (r2_sign),
        .o_valid (w_av),
        .o_quo   (w_aq),
        .o_side  (w_as)
    );

    // delay line so the temperature term lands with z
    logic                        r_ad_v [dpm_pkg::A_DLY];
    logic [dpm_pkg::A_QUO_W-1:0] r_ad_q [dpm_pkg::A_DLY];
    logic                        r_ad_s [dpm_pkg::A_DLY];

    logic                        w_adv;
    logic [dpm_pkg::A_QUO_W-1:0] w_adq;
    logic                        w_ads;
    assign w_adv = r_ad_v[dpm_pkg::A_DLY-1];
    assign w_adq = r_ad_q[dpm_pkg::A_DLY-1];
    assign w_ads = r_ad_s[dpm_pkg::A_DLY-1];

    // ---------------------------------------------------------- series stages
    logic               r3_valid, r4_valid, r5_valid, r6_valid, r7_valid;
    logic               r8_valid, r9_valid, r10_valid, r11_valid;
    logic               r12_valid, r13_valid, r14_valid;

    logic [P_W-1:0]     r3_z, r3_z2, r4_z2, r5_z2, r6_z2;
    logic [P_W-1:0]     r4_p3, r5_p5, r6_p7, r7_p9;
    logic [27:0]        r5_t3, r6_t5, r7_t7, r8_t9;
    logic [29:0]        r4_acc, r5_acc, r6_acc, r7_acc, r8_acc, r9_acc;
    logic signed [21:0] r3_a, r4_a, r5_a, r6_a, r7_a, r8_a, r9_a, r10_a, r11_a;
    logic [3:0]         r3_k, r4_k, r5_k, r6_k, r7_k, r8_k, r9_k;
    logic               r3_zero, r4_zero, r5_zero, r6_zero, r7_zero, r8_zero;
    logic               r9_zero, r10_zero, r11_zero, r12_zero, r13_zero, r14_zero;
    logic signed [35:0] r10_ln30;
    logic signed [21:0] r11_ln16;
    logic signed [22:0] r12_s;
    logic signed [47:0] r13_prod;
    logic [21:0]        r13_dd;
    logic [dpm_pkg::D_NUM_W-1:0] r14_num;
    logic [dpm_pkg::D_DEN_W-1:0] r14_den;
    logic               r14_sign;

    // stage 3 inputs
    logic signed [21:0] w_a;
    logic [57:0]        w_zz;
    assign w_a  = w_ads ? -signed'({1'b0, w_adq}) : signed'({1'b0, w_adq});
    assign w_zz = 58'(w_zq) * 58'(w_zq);

    // odd powers, each times z^2 >> 30
    logic [57:0] w_p3f, w_p5f, w_p7f, w_p9f;
    assign w_p3f = 58'(r3_z)  * 58'(r3_z2);
    assign w_p5f = 58'(r4_p3) * 58'(r4_z2);
    assign w_p7f = 58'(r5_p5) * 58'(r5_z2);
    assign w_p9f = 58'(r6_p7) * 58'(r6_z2);

    // floor division by 3, 5, 7, 9 via reciprocal multiply
    logic [60:0] w_t3f, w_t5f, w_t7f, w_t9f;
    assign w_t3f = 61'(r4_p3) * 61'(dpm_pkg::RECIP_3);
    assign w_t5f = 61'(r5_p5) * 61'(dpm_pkg::RECIP_5);
    assign w_t7f = 61'(r6_p7) * 61'(dpm_pkg::RECIP_7);
    assign w_t9f = 61'(r7_p9) * 61'(dpm_pkg::RECIP_9);

    // ln(h/25600) in q30
    logic [33:0] w_kln2;
    assign w_kln2 = 34'(r9_k) * 34'(dpm_pkg::LN2_Q30);

    // q30 -> q16, round half away from zero
    logic [34:0] w_lnmag;
    logic [35:0] w_lnrnd;
    logic [20:0] w_lnq;
    assign w_lnmag = r10_ln30[35] ? 35'(-r10_ln30) : 35'(r10_ln30);
    assign w_lnrnd = 36'(w_lnmag) + 36'd8192;
    assign w_lnq   = w_lnrnd[34:14];

    // numerator 243.04*s and denominator (17.625-s)*256
    logic signed [22:0] w_dd;
    assign w_dd = 23'(signed'({2'b0, dpm_pkg::K_A_Q16})) - r12_s;

    logic [dpm_pkg::D_NUM_W-1:0] w_mag3;
    assign w_mag3 = r13_prod[47] ? dpm_pkg::D_NUM_W'(-r13_prod)
                                 : dpm_pkg::D_NUM_W'(r13_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r3_valid  <= 1'b0;
            r4_valid  <= 1'b0;
            r5_valid  <= 1'b0;
            r6_valid  <= 1'b0;
            r7_valid  <= 1'b0;
            r8_valid  <= 1'b0;
            r9_valid  <= 1'b0;
            r10_valid <= 1'b0;
            r11_valid <= 1'b0;
            r12_valid <= 1'b0;
            r13_valid <= 1'b0;
            r14_valid <= 1'b0;
            for (int i = 0; i < dpm_pkg::A_DLY; i++) begin
                r_ad_v[i] <= 1'b0;
            end
        end else if (en) begin
            r1_valid  <= i_valid;
            r2_valid  <= r1_valid;
            r3_valid  <= w_zv;
            r4_valid  <= r3_valid;
            r5_valid  <= r4_valid;
            r6_valid  <= r5_valid;
            r7_valid  <= r6_valid;
            r8_valid  <= r7_valid;
            r9_valid  <= r8_valid;
            r10_valid <= r9_valid;
            r11_valid <= r10_valid;
            r12_valid <= r11_valid;
            r13_valid <= r12_valid;
            r14_valid <= r13_valid;
            r_ad_v[0] <= w_av;
            for (int i = 1; i < dpm_pkg::A_DLY; i++) begin
                r_ad_v[i] <= r_ad_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1
            r1_prod  <= w_prod1;
            r1_d1    <= w_d1[24:0];
            r1_mfrac <= w_mw[15:0];
            r1_k     <= w_k;
            r1_zero  <= w_zero;
            // stage 2
            r2_num   <= w_mag1 + 44'(r1_d1 >> 1);
            r2_den   <= r1_d1;
            r2_sign  <= r1_prod[44];
            // alignment
            r_ad_q[0] <= w_aq;
            r_ad_s[0] <= w_as;
            for (int i = 1; i < dpm_pkg::A_DLY; i++) begin
                r_ad_q[i] <= r_ad_q[i-1];
                r_ad_s[i] <= r_ad_s[i-1];
            end
            // stage 3: z and z^2
            r3_z    <= w_zq;
            r3_z2   <= P_W'(w_zz >> 30);
            r3_a    <= w_a;
            r3_k    <= w_zside[4:1];
            r3_zero <= w_zside[0];
            // stage 4
            r4_p3   <= P_W'(w_p3f >> 30);
            r4_z2   <= r3_z2;
            r4_acc  <= 30'(r3_z);
            r4_a    <= r3_a;
            r4_k    <= r3_k;
            r4_zero <= r3_zero;
            // stage 5
            r5_p5   <= P_W'(w_p5f >> 30);
            r5_t3   <= w_t3f[60:dpm_pkg::RECIP_SH];
            r5_z2   <= r4_z2;
            r5_acc  <= r4_acc;
            r5_a    <= r4_a;
            r5_k    <= r4_k;
            r5_zero <= r4_zero;
            // stage 6
            r6_p7   <= P_W'(w_p7f >> 30);
            r6_t5   <= w_t5f[60:dpm_pkg::RECIP_SH];
            r6_z2   <= r5_z2;
            r6_acc  <= r5_acc + 30'(r5_t3);
            r6_a    <= r5_a;
            r6_k    <= r5_k;
            r6_zero <= r5_zero;
            // stage 7
            r7_p9   <= P_W'(w_p9f >> 30);
            r7_t7   <= w_t7f[60:dpm_pkg::RECIP_SH];
            r7_acc  <= r6_acc + 30'(r6_t5);
            r7_a    <= r6_a;
            r7_k    <= r6_k;
            r7_zero <= r6_zero;
            // stage 8
            r8_t9   <= w_t9f[60:dpm_pkg::RECIP_SH];
            r8_acc  <= r7_acc + 30'(r7_t7);
            r8_a    <= r7_a;
            r8_k    <= r7_k;
            r8_zero <= r7_zero;
            // stage 9
            r9_acc  <= r8_acc + 30'(r8_t9);
            r9_a    <= r8_a;
            r9_k    <= r8_k;
            r9_zero <= r8_zero;
            // stage 10: k*ln2 + 2*series - ln(25600)
            r10_ln30 <= signed'(36'(w_kln2) + 36'({r9_acc, 1'b0})
                                - 36'(dpm_pkg::LN25600_Q30));
            r10_a    <= r9_a;
            r10_zero <= r9_zero;
            // stage 11
            r11_ln16 <= r10_ln30[35] ? -signed'({1'b0, w_lnq}) : signed'({1'b0, w_lnq});
            r11_a    <= r10_a;
            r11_zero <= r10_zero;
            // stage 12
            r12_s    <= 23'(r11_ln16) + 23'(r11_a);
            r12_zero <= r11_zero;
            // stage 13
            r13_prod <= 48'(r12_s) * 48'(signed'({1'b0, dpm_pkg::K_B_Q16}));
            r13_dd   <= w_dd[21:0];
            r13_zero <= r12_zero;
            // stage 14: bias is half the (even) divisor
            r14_num  <= w_mag3 + dpm_pkg::D_NUM_W'({r13_dd, 7'd0});
            r14_den  <= {r13_dd, 8'd0};
            r14_sign <= r13_prod[47];
            r14_zero <= r13_zero;
        end
    end

    // final divide, quotient is the rounded dew point magnitude
    logic                        w_dv;
    logic [dpm_pkg::D_QUO_W-1:0] w_dq;
    logic [1:0]                  w_dside;

    dpm_div_pipe #(
        .NUM_W  (dpm_pkg::D_NUM_W),
        .DEN_W  (dpm_pkg::D_DEN_W),
        .QUO_W  (dpm_pkg::D_QUO_W),
        .SIDE_W (2)
    ) u_ddiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r14_valid),
        .i_num   (r14_num),
        .i_den   (r14_den),
        .i_side  ({r14_sign, r14_zero}),
        .o_valid (w_dv),
        .o_quo   (w_dq),
        .o_side  (w_dside)
    );

    // sign, saturation and the invalid case
    dpm_pkg::t_dpm_out n_out_data;
    logic [dpm_pkg::D_QUO_W-1:0] w_dneg;
    assign w_dneg = ~w_dq + 1'b1;

    always_comb begin
        n_out_data.dewpoint_c = signed'(w_dq[15:0]);
        n_out_data.status     = dpm_pkg::ST_OK;
        if (w_dside[0]) begin
            n_out_data.dewpoint_c = '0;
            n_out_data.status     = dpm_pkg::ST_INVALID;
        end else if (w_dside[1]) begin
            if (w_dq > 17'd32768) begin
                n_out_data.dewpoint_c = 16'sh8000;
                n_out_data.status     = dpm_pkg::ST_SAT;
            end else begin
                n_out_data.dewpoint_c = signed'(w_dneg[15:0]);
            end
        end else if (w_dq > 17'd32767) begin
            n_out_data.dewpoint_c = 16'sh7fff;
            n_out_data.status     = dpm_pkg::ST_SAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

`ifndef ASSERT_OFF
    // both divider paths must deliver the same transaction together
    a_path_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv == w_zv)
        else $error("temperature and log paths out of step");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data.status == dpm_pkg::ST_INVALID)
        |-> r_out_data.dewpoint_c == 16'sd0)
        else $error("invalid result with nonzero dew point");

    a_sat_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data.status == dpm_pkg::ST_SAT)
        |-> (r_out_data.dewpoint_c == 16'sh7fff) || (r_out_data.dewpoint_c == 16'sh8000))
        else $error("saturated result not at a range end");
`endif

endmodule

// File: tb/dewpoint_magnus_checker.sv
// checker for the dew point pipeline: predicts each result and compares in order
module dewpoint_magnus_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  dpm_pkg::t_dpm_in   i_data,
    input  logic               o_valid,
    input  logic               i_stall,
    input  dpm_pkg::t_dpm_out  o_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_sat_count
);
    timeunit 1ns;
    timeprecision 1ps;

    dpm_pkg::t_dpm_out dewpoint_queue[$];

    initial begin
        o_fail_count = 0;
        o_sat_count  = 0;
    end

    assign o_pending = dewpoint_queue.size();

    // rounds to nearest, ties away from zero, for a positive divisor
    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = (mag + den / 2) / den;
        return (num < 0) ? -quo : quo;
    endfunction

    // ln(h / 100 percent) in q16 from a q30 odd-power series
    function automatic longint ln_humidity_q16(logic [14:0] h);
        int          msb;
        logic [63:0] mant;
        logic [63:0] z;
        logic [63:0] z_sq;
        logic [63:0] pwr;
        logic [63:0] acc;
        longint      ln_q30;
        msb = 14;
        while (msb > 0 && h[msb] == 1'b0)
            msb--;
        mant = 64'(h) << (16 - msb);
        z    = ((mant - 64'd65536) << 30) / (mant + 64'd65536);
        z_sq = (z * z) >> 30;
        pwr  = z;
        acc  = z;
        for (int n = 3; n <= 9; n += 2) begin
            pwr = (pwr * z_sq) >> 30;
            acc = acc + pwr / 64'(n);
        end
        ln_q30 = longint'(msb) * longint'(dpm_pkg::LN2_Q30) + longint'(2 * acc)
               - longint'(dpm_pkg::LN25600_Q30);
        return round_div(ln_q30, 16384);
    endfunction

    function automatic dpm_pkg::t_dpm_out dewpoint_of(dpm_pkg::t_dpm_in smp);
        dpm_pkg::t_dpm_out res;
        longint            t_q16;
        longint            a_term;
        longint            s_sum;
        longint            dp;
        if (smp.humidity_pct == '0) begin
            res.dewpoint_c = '0;
            res.status     = dpm_pkg::ST_INVALID;
            return res;
        end
        t_q16  = longint'(smp.temperature_c) * 256;
        a_term = round_div(longint'(dpm_pkg::K_A_Q16) * t_q16,
                           longint'(dpm_pkg::K_B_Q16) + t_q16);
        s_sum  = ln_humidity_q16(smp.humidity_pct) + a_term;
        dp     = round_div(longint'(dpm_pkg::K_B_Q16) * s_sum,
                           (longint'(dpm_pkg::K_A_Q16) - s_sum) * 256);
        res.status = dpm_pkg::ST_OK;
        if (dp > 32767) begin
            dp = 32767;
            res.status = dpm_pkg::ST_SAT;
        end else if (dp < -32768) begin
            dp = -32768;
            res.status = dpm_pkg::ST_SAT;
        end
        res.dewpoint_c = 16'(dp);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%t mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        dpm_pkg::t_dpm_out want;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                dewpoint_queue.push_back(dewpoint_of(i_data));
            if (o_valid && !i_stall) begin
                if (dewpoint_queue.size() == 0) begin
                    report_mismatch("result with no transaction pending");
                end else begin
                    want = dewpoint_queue.pop_front();
                    if (o_data.status == dpm_pkg::ST_SAT)
                        o_sat_count++;
                    if (o_data.dewpoint_c !== want.dewpoint_c)
                        report_mismatch($sformatf("dewpoint got %0d want %0d",
                            o_data.dewpoint_c, want.dewpoint_c));
                    if (o_data.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                            o_data.status, want.status));
                end
            end
        end
    end

endmodule

// File: tb/dewpoint_magnus_test.sv
// top of the dew point testbench: clock, reset, stimulus and verdict
module dewpoint_magnus_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_CYCLES = 100;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    dpm_pkg::t_dpm_in  i_data;
    logic              o_valid;
    logic              i_stall;
    dpm_pkg::t_dpm_out o_data;

    int fail_count;
    int pending;
    int sat_count;
    int sent_count;
    int zero_rh_count;
    int stall_mode;

    dewpoint_magnus dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    dewpoint_magnus_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data       (i_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_sat_count  (sat_count)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // receiver stall pattern: a mode picked every so often, from no stall to heavy
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 9) < 2);
            2: i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= ~i_stall;
        endcase
    end

    // present one transaction and hold it until the block takes it;
    // valid stays high so back-to-back items in a burst leave no bubble
    task automatic send_sample(logic signed [15:0] temp, logic [14:0] rh);
        i_valid <= 1'b1;
        i_data.temperature_c <= temp;
        i_data.humidity_pct  <= rh;
        do
            @(posedge i_clk);
        while (o_stall);
        sent_count++;
        if (rh == '0)
            zero_rh_count++;
    endtask

    task automatic idle_gap(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // mostly the stated sensor range, some full-width values, a few zero humidity
    task automatic send_random_sample();
        logic signed [15:0] temp;
        logic [14:0]        rh;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            temp = 16'($urandom_range(0, 32000)) - 16'sd10240;
            rh   = 15'($urandom_range(1, 25600));
        end else if (pick < 93) begin
            temp = 16'($urandom);
            rh   = 15'($urandom);
        end else if (pick < 97) begin
            temp = 16'($urandom);
            rh   = '0;
        end else begin
            // very dry or very hot/cold corners push the result toward saturation
            temp = $urandom_range(0, 1) ? 16'sh7F00 + 16'($urandom_range(0, 255))
                                        : 16'sh8000 + 16'($urandom_range(0, 255));
            rh   = $urandom_range(0, 1) ? 15'($urandom_range(1, 8)) : 15'h7FFF;
        end
        send_sample(temp, rh);
    endtask

    initial begin
        int left;
        int burst;
        int waited;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_data        = '0;
        stall_mode    = 0;
        sent_count    = 0;
        zero_rh_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: field extremes, sensor range ends, zero humidity,
        // humidity above 100 percent and single-bit humidity values
        send_sample(16'sh8000, 15'd1);
        send_sample(16'sh7FFF, 15'h7FFF);
        send_sample(16'sh8000, 15'h7FFF);
        send_sample(16'sh7FFF, 15'd1);
        send_sample(-16'sd10240, 15'd25600);
        send_sample(16'sd21760, 15'd25600);
        send_sample(16'sd0, 15'd25600);
        send_sample(16'sd6400, 15'd12800);
        send_sample(16'sd0, 15'd0);
        send_sample(16'sh7FFF, 15'd0);
        send_sample(16'sh8000, 15'd0);
        idle_gap(3);
        send_sample(-16'sd10240, 15'd256);
        send_sample(16'sd21760, 15'd1);
        send_sample(16'sd5120, 15'd16384);
        send_sample(16'sd5120, 15'd16383);
        send_sample(16'sd5120, 15'd2);
        send_sample(16'sh5555, 15'h2AAA);
        send_sample(-16'sh5556, 15'h5555);
        send_sample(-16'sd1, 15'd25601);

        left = RANDOM_ITEMS;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst) send_random_sample();
            left -= burst;
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 8));
        end
        i_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d samples (%0d with zero humidity), %0d results saturated",
            sent_count, zero_rh_count, sat_count);
        $display("stalls and source gaps mixed, %0d mismatches, %0d results missing",
            fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5ms;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/dpm_pkg.sv
rtl/core/dpm_div_pipe.sv
rtl/core/dewpoint_magnus.sv
tb/dewpoint_magnus_checker.sv
tb/dewpoint_magnus_test.sv
